/* sv/dd_odo_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dd_odo_pkg: shared types and constants for the odometry block
// Holds the sequencer states, register indexes, CORDIC constants and helpers.
// ----------------------------------------------------------------------------
package dd_odo_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CORDIC,
        ST_DONE
    } state_t;

    // Multiplier passes, in the order they run
    typedef enum logic [2:0] {
        PH_LEFT,
        PH_RIGHT,
        PH_TURN,
        PH_COS,
        PH_SIN
    } phase_t;

    // Register indexes on the configuration port
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_DIST_PER_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_PER_DIST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_HEADING = 3'd4;

    // Register reset values
    localparam logic [31:0] DIST_PER_COUNT_RST = 32'd16777216;
    localparam logic [31:0] TURN_PER_DIST_RST  = 32'd65536;

    // Serial multiplier: one multiplier bit per cycle
    localparam int unsigned MUL_BITS = 32;
    localparam int unsigned MUL_CNT_W = 5;
    localparam logic [MUL_CNT_W-1:0] MUL_LAST = 5'(MUL_BITS - 1);

    // CORDIC datapath width and start value (gain in Q1.30)
    localparam int unsigned CW = 34;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam int unsigned ATAN_IDX_W = 5;

    // Arctangent table, binary angle units
    function automatic logic [29:0] atan_value(input logic [ATAN_IDX_W-1:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            5'd24: v = 30'd41;
            5'd25: v = 30'd20;
            5'd26: v = 30'd10;
            5'd27: v = 30'd5;
            5'd28: v = 30'd3;
            5'd29: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // Saturate a 64-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* sv/differential_drive_odometry.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry: pose tracking from wheel encoder counts
// Integrates x, y and heading with a bit-serial multiplier and an iterative
// CORDIC for sine and cosine.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  in       | in_valid / in_stall    | kind, left_count, right_count
//  out      | out_valid / out_stall  | pos_x, pos_y, heading, moved
//  cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  A sample that moves the pose runs five passes of the shared serial multiplier
//  (left and right distance, turn, cosine and sine steps) and the CORDIC steps.
//  Set-origin items, first samples and unchanged samples skip the multiplier.
//  One item is in work at a time; the next is accepted while a result waits.
//  Reset clears the pose, the previous counts and all control state.
//  A stalled result holds in the output register until it is taken.
// ----------------------------------------------------------------------------
module differential_drive_odometry #(
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 kind,
    input  logic signed [31:0]                   left_count,
    input  logic signed [31:0]                   right_count,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [31:0]                   pos_x,
    output logic signed [31:0]                   pos_y,
    output logic [31:0]                          heading,
    output logic                                 moved,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dd_odo_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                          cfg_data
);

    localparam int unsigned CW = dd_odo_pkg::CW;
    localparam int unsigned SW = $clog2(CORDIC_STEPS + 1);
    localparam logic [SW-1:0] STEP_LAST = SW'(CORDIC_STEPS - 1);

    // Configuration registers
    logic [31:0]        dpc_reg, dpc_next;
    logic [31:0]        tpd_reg, tpd_next;
    logic signed [31:0] ox_reg, ox_next;
    logic signed [31:0] oy_reg, oy_next;
    logic [31:0]        oh_reg, oh_next;

    // Pose and previous counts
    logic [31:0]        prev_l_reg, prev_l_next;
    logic [31:0]        prev_r_reg, prev_r_next;
    logic               have_prev_reg, have_prev_next;
    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] y_reg, y_next;
    logic [31:0]        h_reg, h_next;

    // Sequencer
    dd_odo_pkg::state_t state_reg, state_next;
    dd_odo_pkg::phase_t phase_reg, phase_next;
    logic               moved_reg, moved_next;

    // Serial multiplier
    logic [63:0]                       acc_reg, acc_next;
    logic [63:0]                       mcand_reg, mcand_next;
    logic [31:0]                       mplier_reg, mplier_next;
    logic [dd_odo_pkg::MUL_CNT_W-1:0]  mcnt_reg, mcnt_next;

    // Distances and mean
    logic [31:0]        dr_reg, dr_next;
    logic signed [63:0] ldist_reg, ldist_next;
    logic signed [31:0] mean_reg, mean_next;

    // CORDIC
    logic signed [CW-1:0] cx_reg, cx_next;
    logic signed [CW-1:0] cy_reg, cy_next;
    logic signed [CW-1:0] cz_reg, cz_next;
    logic                 flip_reg, flip_next;
    logic [SW-1:0]        ccnt_reg, ccnt_next;

    // Output register
    logic               ov_reg, ov_next;
    logic signed [31:0] ox_out_reg, ox_out_next;
    logic signed [31:0] oy_out_reg, oy_out_next;
    logic [31:0]        oh_out_reg, oh_out_next;
    logic               om_out_reg, om_out_next;

    // Working values
    logic [31:0]          dl_w, dr_w;
    logic [63:0]          addend_w, acc_w;
    logic                 sub_w;
    logic signed [63:0]   dist_w, rsum_w, diff_w, step_w, pos_sum_w;
    logic [31:0]          hnew_w;
    logic                 fnew_w;
    logic signed [CW-1:0] xs_w, ys_w, atan_w, cxn_w, cyn_w, czn_w;

    assign in_stall  = (state_reg != dd_odo_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = ov_reg;
    assign pos_x     = ox_out_reg;
    assign pos_y     = oy_out_reg;
    assign heading   = oh_out_reg;
    assign moved     = om_out_reg;

    // Register writes
    always_comb
    begin
        dpc_next = dpc_reg;
        tpd_next = tpd_reg;
        ox_next  = ox_reg;
        oy_next  = oy_reg;
        oh_next  = oh_reg;
        if (cfg_valid) begin
            case (cfg_index)
                dd_odo_pkg::REG_DIST_PER_COUNT: dpc_next = cfg_data;
                dd_odo_pkg::REG_TURN_PER_DIST:  tpd_next = cfg_data;
                dd_odo_pkg::REG_ORIGIN_X:       ox_next  = cfg_data;
                dd_odo_pkg::REG_ORIGIN_Y:       oy_next  = cfg_data;
                dd_odo_pkg::REG_ORIGIN_HEADING: oh_next  = cfg_data;
                default: ;
            endcase
        end
    end

    // Datapath helpers
    always_comb
    begin
        dl_w = left_count - prev_l_reg;
        dr_w = right_count - prev_r_reg;

        // one multiplier bit; the sign bit of a signed multiplier subtracts
        addend_w = mplier_reg[0] ? mcand_reg : 64'd0;
        sub_w    = ((phase_reg == dd_odo_pkg::PH_COS) || (phase_reg == dd_odo_pkg::PH_SIN))
                   && (mcnt_reg == dd_odo_pkg::MUL_LAST);
        acc_w    = sub_w ? (acc_reg - addend_w) : (acc_reg + addend_w);

        dist_w    = $signed(acc_w) >>> 8;
        rsum_w    = (ldist_reg + dist_w) >>> 1;
        diff_w    = dist_w - ldist_reg;
        step_w    = $signed(acc_w) >>> 30;
        pos_sum_w = (phase_reg == dd_odo_pkg::PH_COS)
                    ? (64'(x_reg) + step_w) : (64'(y_reg) + step_w);

        // new heading and quadrant fold into the first and fourth quadrants
        hnew_w = h_reg + acc_w[63:32];
        fnew_w = hnew_w[31] ^ hnew_w[30];

        // one CORDIC rotation
        xs_w   = cx_reg >>> ccnt_reg;
        ys_w   = cy_reg >>> ccnt_reg;
        atan_w = {{(CW-30){1'b0}}, dd_odo_pkg::atan_value(
                     dd_odo_pkg::ATAN_IDX_W'(ccnt_reg))};
        if (!cz_reg[CW-1]) begin
            cxn_w = cx_reg - ys_w;
            cyn_w = cy_reg + xs_w;
            czn_w = cz_reg - atan_w;
        end else begin
            cxn_w = cx_reg + ys_w;
            cyn_w = cy_reg - xs_w;
            czn_w = cz_reg + atan_w;
        end
    end

    // Sequencer and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        moved_next     = moved_reg;
        prev_l_next    = prev_l_reg;
        prev_r_next    = prev_r_reg;
        have_prev_next = have_prev_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        h_next         = h_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        mcnt_next      = mcnt_reg;
        dr_next        = dr_reg;
        ldist_next     = ldist_reg;
        mean_next      = mean_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;
        flip_next      = flip_reg;
        ccnt_next      = ccnt_reg;
        ov_next        = ov_reg && out_stall;
        ox_out_next    = ox_out_reg;
        oy_out_next    = oy_out_reg;
        oh_out_next    = oh_out_reg;
        om_out_next    = om_out_reg;

        unique case (state_reg)
            dd_odo_pkg::ST_IDLE:
            begin
                if (in_valid) begin
                    prev_l_next    = left_count;
                    prev_r_next    = right_count;
                    have_prev_next = 1'b1;
                    moved_next     = 1'b0;
                    state_next     = dd_odo_pkg::ST_DONE;
                    if (kind) begin
                        // load the pose from the origin registers
                        x_next = ox_reg;
                        y_next = oy_reg;
                        h_next = oh_reg;
                    end else if (have_prev_reg && ((dl_w != 32'd0) || (dr_w != 32'd0))) begin
                        // start the left distance pass
                        moved_next  = 1'b1;
                        dr_next     = dr_w;
                        acc_next    = 64'd0;
                        mcand_next  = {{32{dl_w[31]}}, dl_w};
                        mplier_next = dpc_reg;
                        mcnt_next   = '0;
                        phase_next  = dd_odo_pkg::PH_LEFT;
                        state_next  = dd_odo_pkg::ST_MUL;
                    end
                end
            end

            dd_odo_pkg::ST_MUL:
            begin
                acc_next    = acc_w;
                mcand_next  = {mcand_reg[62:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[31:1]};
                mcnt_next   = mcnt_reg + 1'b1;
                if (mcnt_reg == dd_odo_pkg::MUL_LAST) begin
                    acc_next  = 64'd0;
                    mcnt_next = '0;
                    case (phase_reg)
                        dd_odo_pkg::PH_LEFT:
                        begin
                            ldist_next  = dist_w;
                            mcand_next  = {{32{dr_reg[31]}}, dr_reg};
                            mplier_next = dpc_reg;
                            phase_next  = dd_odo_pkg::PH_RIGHT;
                        end
                        dd_odo_pkg::PH_RIGHT:
                        begin
                            mean_next   = dd_odo_pkg::sat32(rsum_w);
                            mcand_next  = diff_w;
                            mplier_next = tpd_reg;
                            phase_next  = dd_odo_pkg::PH_TURN;
                        end
                        dd_odo_pkg::PH_TURN:
                        begin
                            h_next     = hnew_w;
                            flip_next  = fnew_w;
                            cx_next    = dd_odo_pkg::CORDIC_GAIN;
                            cy_next    = '0;
                            cz_next    = CW'($signed({hnew_w[31] ^ fnew_w, hnew_w[30:0]}));
                            ccnt_next  = '0;
                            state_next = dd_odo_pkg::ST_CORDIC;
                        end
                        dd_odo_pkg::PH_COS:
                        begin
                            x_next      = dd_odo_pkg::sat32(pos_sum_w);
                            mcand_next  = 64'(cy_reg);
                            mplier_next = mean_reg;
                            phase_next  = dd_odo_pkg::PH_SIN;
                        end
                        default:
                        begin
                            y_next     = dd_odo_pkg::sat32(pos_sum_w);
                            state_next = dd_odo_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            dd_odo_pkg::ST_CORDIC:
            begin
                cx_next   = cxn_w;
                cy_next   = cyn_w;
                cz_next   = czn_w;
                ccnt_next = ccnt_reg + 1'b1;
                if (ccnt_reg == STEP_LAST) begin
                    // unfold the quadrant and start the cosine step pass
                    cx_next     = flip_reg ? -cxn_w : cxn_w;
                    cy_next     = flip_reg ? -cyn_w : cyn_w;
                    acc_next    = 64'd0;
                    mcand_next  = 64'(flip_reg ? -cxn_w : cxn_w);
                    mplier_next = mean_reg;
                    mcnt_next   = '0;
                    phase_next  = dd_odo_pkg::PH_COS;
                    state_next  = dd_odo_pkg::ST_MUL;
                end
            end

            dd_odo_pkg::ST_DONE:
            begin
                // hand the result over once the output register is free
                if (!ov_reg || !out_stall) begin
                    ov_next     = 1'b1;
                    ox_out_next = x_reg;
                    oy_out_next = y_reg;
                    oh_out_next = h_reg;
                    om_out_next = moved_reg;
                    state_next  = dd_odo_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = dd_odo_pkg::ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= dd_odo_pkg::ST_IDLE;
            phase_reg     <= dd_odo_pkg::PH_LEFT;
            ov_reg        <= 1'b0;
            have_prev_reg <= 1'b0;
            prev_l_reg    <= '0;
            prev_r_reg    <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            h_reg         <= '0;
            dpc_reg       <= dd_odo_pkg::DIST_PER_COUNT_RST;
            tpd_reg       <= dd_odo_pkg::TURN_PER_DIST_RST;
            ox_reg        <= '0;
            oy_reg        <= '0;
            oh_reg        <= '0;
            moved_reg     <= 1'b0;
            mcnt_reg      <= '0;
            ccnt_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            ov_reg        <= ov_next;
            have_prev_reg <= have_prev_next;
            prev_l_reg    <= prev_l_next;
            prev_r_reg    <= prev_r_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            h_reg         <= h_next;
            dpc_reg       <= dpc_next;
            tpd_reg       <= tpd_next;
            ox_reg        <= ox_next;
            oy_reg        <= oy_next;
            oh_reg        <= oh_next;
            moved_reg     <= moved_next;
            mcnt_reg      <= mcnt_next;
            ccnt_reg      <= ccnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        dr_reg     <= dr_next;
        ldist_reg  <= ldist_next;
        mean_reg   <= mean_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        cz_reg     <= cz_next;
        flip_reg   <= flip_next;
        ox_out_reg <= ox_out_next;
        oy_out_reg <= oy_out_next;
        oh_out_reg <= oh_out_next;
        om_out_reg <= om_out_next;
    end

endmodule

/* sv/dd_odo_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dd_odo_check: port-level checks for the odometry block
// Watches the handshakes on the top level and is bound to it below.
// ----------------------------------------------------------------------------
module dd_odo_check (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic signed [31:0]               pos_x,
    input logic signed [31:0]               pos_y,
    input logic [31:0]                      heading,
    input logic                             moved
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // Keep a stalled payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(pos_x) && $stable(pos_y)
                                   && $stable(heading) && $stable(moved))
        else $error("stalled result changed");

    // Go busy after an accepted item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken while one is in work");

    // Raise a result only out of a busy cycle
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared with no item in work");

endmodule

bind differential_drive_odometry dd_odo_check u_dd_odo_check (.*);
